@@ rtl/tlsc_pkg.sv @@
// ----------------------------------------------------------------------------
// tlsc_pkg - shared types and constants for the toroidal life stepper
// Command and register codes, field widths, hash weights, the control
// state type and the request/response structs of the history ring.
// ----------------------------------------------------------------------------
package tlsc_pkg;

	// field widths fixed by the item format
	localparam int CMD_W     = 2;
	localparam int COORD_W   = 5;
	localparam int DIM_W     = 6;
	localparam int HASH_W    = 18;
	localparam int CFG_IDX_W = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_GEN   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

	// reset value of both grid dimensions
	localparam logic [DIM_W-1:0] DIM_RESET = 6'd16;

	// hash weights: 3 per column, 5 per row
	localparam logic [HASH_W-1:0] X_WEIGHT = 18'd3;
	localparam logic [HASH_W-1:0] Y_WEIGHT = 18'd5;

	// control sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CELL_WR,
		ST_CELL_RD,
		ST_GEN_PREV,
		ST_GEN_CUR,
		ST_GEN_ROW,
		ST_GEN_HASH,
		ST_GEN_HIST,
		ST_RESULT
	} tlsc_state_t;

	// history ring request: store a new hash and scan for an equal entry
	typedef struct packed {
		logic              start;
		logic [HASH_W-1:0] hash;
	} hist_req_t;

	// history ring response
	typedef struct packed {
		logic busy;
		logic done;
		logic hit;
	} hist_rsp_t;

endpackage

@@ rtl/tlsc_ram.sv @@
// ----------------------------------------------------------------------------
// tlsc_ram - generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tlsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_data_q <= mem_q[raddr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/tlsc_row_rule.sv @@
// ----------------------------------------------------------------------------
// tlsc_row_rule - B3/S23 update of one grid row
// One lane per column counts the eight neighbors from the rows above, at
// and below, wrapping at the active width. Columns past the width keep
// their value.
// ----------------------------------------------------------------------------
module tlsc_row_rule #(
	parameter int SIDE = 32
) (
	input  logic [SIDE-1:0]              prev_row,
	input  logic [SIDE-1:0]              cur_row,
	input  logic [SIDE-1:0]              next_row,
	input  logic [tlsc_pkg::DIM_W-1:0]   width,
	output logic [SIDE-1:0]              new_row
);

	localparam int DW = tlsc_pkg::DIM_W;
	localparam int AW = $clog2(SIDE);

	logic [DW-1:0] wm1;
	logic [AW-1:0] wrap_idx;
	logic          wrap_p;
	logic          wrap_c;
	logic          wrap_n;

	// left neighbor of column 0 is the last active column
	assign wm1      = width - DW'(1);
	assign wrap_idx = AW'(wm1);
	assign wrap_p   = prev_row[wrap_idx];
	assign wrap_c   = cur_row[wrap_idx];
	assign wrap_n   = next_row[wrap_idx];

	for (genvar i = 0; i < SIDE; i++) begin : g_lane
		logic       l_p, l_c, l_n;
		logic       r_p, r_c, r_n;
		logic [7:0] nb;
		logic [3:0] cnt;

		// left neighbors
		if (i == 0) begin : g_left_wrap
			assign l_p = wrap_p;
			assign l_c = wrap_c;
			assign l_n = wrap_n;
		end else begin : g_left
			assign l_p = prev_row[i-1];
			assign l_c = cur_row[i-1];
			assign l_n = next_row[i-1];
		end

		// right neighbors, wrap to column 0 at the last active column
		if (i < SIDE - 1) begin : g_right
			assign r_p = (width == DW'(i + 1)) ? prev_row[0] : prev_row[i+1];
			assign r_c = (width == DW'(i + 1)) ? cur_row[0]  : cur_row[i+1];
			assign r_n = (width == DW'(i + 1)) ? next_row[0] : next_row[i+1];
		end else begin : g_right_wrap
			assign r_p = prev_row[0];
			assign r_c = cur_row[0];
			assign r_n = next_row[0];
		end

		assign nb  = {l_p, prev_row[i], r_p, l_c, r_c, l_n, next_row[i], r_n};
		assign cnt = 4'($countones(nb));

		// birth on 3, survival on 2 or 3
		assign new_row[i] = (DW'(i) < width) ?
			((cnt == 4'd3) || (cur_row[i] && (cnt == 4'd2))) : cur_row[i];
	end

endmodule

@@ rtl/tlsc_hist.sv @@
// ----------------------------------------------------------------------------
// tlsc_hist - ring of generation hashes with a repeat scan
// On start the pointer advances, the hash is written there, and every
// other entry is read back one per cycle and compared with it. Entries
// never written read as zero.
// ----------------------------------------------------------------------------
module tlsc_hist #(
	parameter int DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tlsc_pkg::hist_req_t  req,
	output tlsc_pkg::hist_rsp_t  rsp
);

	localparam int HW = tlsc_pkg::HASH_W;
	localparam int PW = $clog2(DEPTH);

	logic [PW-1:0]    ptr_q;
	logic [PW-1:0]    ptr_nxt;
	logic [PW-1:0]    scan_k_q;
	logic             busy_q;
	logic             hit_q;
	logic [HW-1:0]    hash_q;
	logic [DEPTH-1:0] ent_vld_q;
	logic             rd_act_s1;
	logic [PW-1:0]    rd_k_s1;
	logic             rd_vld_s1;
	logic [HW-1:0]    rd_data;
	logic [HW-1:0]    ent_val;
	logic             match;
	logic             last_k;

	// ring storage
	tlsc_ram #(
		.WIDTH (HW),
		.DEPTH (DEPTH)
	) u_ring (
		.clk     (clk),
		.we      (req.start),
		.waddr   (ptr_nxt),
		.wdata   (req.hash),
		.raddr   (scan_k_q),
		.rd_data (rd_data)
	);

	assign ptr_nxt = (ptr_q == PW'(DEPTH - 1)) ? '0 : ptr_q + PW'(1);
	assign ent_val = rd_vld_s1 ? rd_data : '0;
	assign match   = rd_act_s1 && (rd_k_s1 != ptr_q) && (ent_val == hash_q);
	assign last_k  = (scan_k_q == PW'(DEPTH - 1));

	// pointer, valid bits and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			scan_k_q  <= '0;
			busy_q    <= 1'b0;
			hit_q     <= 1'b0;
			ent_vld_q <= '0;
			rd_act_s1 <= 1'b0;
		end else begin
			rd_act_s1 <= busy_q;
			if (req.start) begin
				ptr_q              <= ptr_nxt;
				ent_vld_q[ptr_nxt] <= 1'b1;
				busy_q             <= 1'b1;
				scan_k_q           <= '0;
				hit_q              <= 1'b0;
			end else begin
				if (busy_q) begin
					scan_k_q <= scan_k_q + PW'(1);
					if (last_k) begin
						busy_q <= 1'b0;
					end
				end
				if (match) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	// read-side pipeline payload
	always_ff @(posedge clk) begin
		if (req.start) begin
			hash_q <= req.hash;
		end
		rd_k_s1   <= scan_k_q;
		rd_vld_s1 <= ent_vld_q[scan_k_q];
	end

	assign rsp.busy = busy_q || rd_act_s1;
	assign rsp.done = rd_act_s1 && (rd_k_s1 == PW'(DEPTH - 1));
	assign rsp.hit  = hit_q || match;

endmodule

@@ rtl/toroidal_life_step_with_cycle_check.sv @@
// ----------------------------------------------------------------------------
// toroidal_life_step_with_cycle_check - Game of Life grid on a torus
// Row-organized cell memory with a sequencer that writes, reads or steps
// the grid one generation, plus a hash history ring that flags repeats.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command per transfer:
//   write a cell, read a cell, or run one generation. Every command yields
//   exactly one result transfer on the output channel (out_valid/out_ready).
//   Configuration writes (cfg_valid/cfg_ready, always ready) set the grid
//   width and height; change them only while the block is idle.
// Sequence:
//   Cell write or read: the command passes its cell state, then the result
//   state; a cell outside the active area, an unknown code or a generation
//   with a zero dimension goes straight to the result state.
//   Generation: each row goes through the neighbor lanes and then the serial
//   hash walk; the ring scan reads one history entry per cycle.
//   One command in flight.
// Reset:
//   All cells read dead and the ring reads zero through per-row and
//   per-entry valid bits; no clearing pass is needed.
// Stalls:
//   The output register holds a result until it is taken; a new command is
//   accepted meanwhile, and its result waits if the register is still full.
// ----------------------------------------------------------------------------
module toroidal_life_step_with_cycle_check #(
	parameter int MAX_SIDE      = 32,
	parameter int HISTORY_DEPTH = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// command channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [tlsc_pkg::CMD_W-1:0]         command,
	input  logic [tlsc_pkg::COORD_W-1:0]       cell_x,
	input  logic [tlsc_pkg::COORD_W-1:0]       cell_y,
	input  logic                               cell_in,
	// result channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               cell_out,
	output logic [tlsc_pkg::HASH_W-1:0]        grid_hash,
	output logic                               repeat_seen,
	// configuration channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tlsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tlsc_pkg::DIM_W-1:0]         cfg_data
);

	localparam int AW = $clog2(MAX_SIDE);
	localparam int DW = tlsc_pkg::DIM_W;
	localparam int HW = tlsc_pkg::HASH_W;
	localparam logic [DW:0] MAX_SIDE_C = (DW + 1)'(MAX_SIDE);

	tlsc_pkg::tlsc_state_t state_q, state_d;

	logic [DW-1:0]       width_q, height_q;
	logic [DW-1:0]       w_eff, h_eff;
	logic                in_xfer, cfg_xfer, in_area;
	logic [MAX_SIDE-1:0] row_vld_q;
	logic                rd_row_vld_s1;

	logic                grid_we;
	logic [AW-1:0]       grid_waddr, grid_raddr;
	logic [MAX_SIDE-1:0] grid_wdata, grid_rdata, grid_row;

	logic [AW-1:0]       x_q, y_q;
	logic                v_q;
	logic [MAX_SIDE-1:0] prev_q, cur_q, row0_q, new_q;
	logic [MAX_SIDE-1:0] next_row, new_row;
	logic [HW-1:0]       acc_q, term_q, base_q, acc_nxt;
	logic                last_row, last_x;

	logic                res_cell_q, res_rep_q;
	logic [HW-1:0]       res_hash_q;
	logic                out_valid_q, cell_out_q, repeat_seen_q;
	logic [HW-1:0]       grid_hash_q;
	logic                out_load;

	tlsc_pkg::hist_req_t hist_req;
	tlsc_pkg::hist_rsp_t hist_rsp;

	// handshakes and effective dimensions
	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign in_xfer   = in_valid && in_ready;
	assign w_eff     = ({1'b0, width_q} > MAX_SIDE_C) ? DW'(MAX_SIDE) : width_q;
	assign h_eff     = ({1'b0, height_q} > MAX_SIDE_C) ? DW'(MAX_SIDE) : height_q;
	assign in_area   = (DW'(cell_x) < w_eff) && (DW'(cell_y) < h_eff);

	// cell grid, one word per row
	tlsc_ram #(
		.WIDTH (MAX_SIDE),
		.DEPTH (MAX_SIDE)
	) u_grid (
		.clk     (clk),
		.we      (grid_we),
		.waddr   (grid_waddr),
		.wdata   (grid_wdata),
		.raddr   (grid_raddr),
		.rd_data (grid_rdata)
	);

	// rows never written read as dead
	assign grid_row = rd_row_vld_s1 ? grid_rdata : '0;

	// generation datapath
	assign last_row = (DW'(y_q) == (h_eff - DW'(1)));
	assign last_x   = (DW'(x_q) == (w_eff - DW'(1)));
	assign next_row = last_row ? row0_q : grid_row;
	assign acc_nxt  = new_q[x_q] ? (acc_q + term_q) : acc_q;

	tlsc_row_rule #(
		.SIDE (MAX_SIDE)
	) u_rule (
		.prev_row (prev_q),
		.cur_row  (cur_q),
		.next_row (next_row),
		.width    (w_eff),
		.new_row  (new_row)
	);

	tlsc_hist #(
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hist_req),
		.rsp    (hist_rsp)
	);

	// sequencer: next state and memory control
	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		grid_we        = 1'b0;
		grid_waddr     = y_q;
		grid_wdata     = new_row;
		grid_raddr     = y_q;
		hist_req.start = 1'b0;
		hist_req.hash  = acc_nxt;
		out_load       = 1'b0;
		case (state_q)
			tlsc_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				grid_raddr = AW'(cell_y);
				if (in_valid) begin
					state_d = tlsc_pkg::ST_RESULT;
					case (command)
						tlsc_pkg::CMD_WRITE: begin
							if (in_area) begin
								state_d = tlsc_pkg::ST_CELL_WR;
							end
						end
						tlsc_pkg::CMD_READ: begin
							if (in_area) begin
								state_d = tlsc_pkg::ST_CELL_RD;
							end
						end
						tlsc_pkg::CMD_GEN: begin
							if ((w_eff != '0) && (h_eff != '0)) begin
								grid_raddr = AW'(h_eff - DW'(1));
								state_d    = tlsc_pkg::ST_GEN_PREV;
							end
						end
						default: begin
							state_d = tlsc_pkg::ST_RESULT;
						end
					endcase
				end
			end
			tlsc_pkg::ST_CELL_WR: begin
				grid_we           = 1'b1;
				grid_wdata        = grid_row;
				grid_wdata[x_q]   = v_q;
				state_d           = tlsc_pkg::ST_RESULT;
			end
			tlsc_pkg::ST_CELL_RD: begin
				state_d = tlsc_pkg::ST_RESULT;
			end
			tlsc_pkg::ST_GEN_PREV: begin
				grid_raddr = '0;
				state_d    = tlsc_pkg::ST_GEN_CUR;
			end
			tlsc_pkg::ST_GEN_CUR: begin
				grid_raddr = AW'(1);
				state_d    = tlsc_pkg::ST_GEN_ROW;
			end
			tlsc_pkg::ST_GEN_ROW: begin
				grid_we = 1'b1;
				state_d = tlsc_pkg::ST_GEN_HASH;
			end
			tlsc_pkg::ST_GEN_HASH: begin
				// prefetch the row below the next one
				grid_raddr = AW'({1'b0, y_q} + (AW + 1)'(2));
				if (last_x) begin
					if (last_row) begin
						hist_req.start = 1'b1;
						state_d        = tlsc_pkg::ST_GEN_HIST;
					end else begin
						state_d = tlsc_pkg::ST_GEN_ROW;
					end
				end
			end
			tlsc_pkg::ST_GEN_HIST: begin
				if (hist_rsp.done) begin
					state_d = tlsc_pkg::ST_RESULT;
				end
			end
			tlsc_pkg::ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = tlsc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tlsc_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= tlsc_pkg::ST_IDLE;
			width_q       <= tlsc_pkg::DIM_RESET;
			height_q      <= tlsc_pkg::DIM_RESET;
			row_vld_q     <= '0;
			rd_row_vld_s1 <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			rd_row_vld_s1 <= row_vld_q[grid_raddr];
			if (grid_we) begin
				row_vld_q[grid_waddr] <= 1'b1;
			end
			if (cfg_xfer) begin
				case (cfg_index)
					tlsc_pkg::REG_GRID_WIDTH:  width_q  <= cfg_data;
					tlsc_pkg::REG_GRID_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			tlsc_pkg::ST_IDLE: begin
				if (in_xfer) begin
					x_q        <= AW'(cell_x);
					y_q        <= AW'(cell_y);
					v_q        <= cell_in;
					res_cell_q <= 1'b0;
					res_hash_q <= '0;
					res_rep_q  <= 1'b0;
				end
			end
			tlsc_pkg::ST_CELL_RD: begin
				res_cell_q <= grid_row[x_q];
			end
			tlsc_pkg::ST_GEN_PREV: begin
				prev_q <= grid_row;
			end
			tlsc_pkg::ST_GEN_CUR: begin
				cur_q  <= grid_row;
				row0_q <= grid_row;
				y_q    <= '0;
				base_q <= '0;
				acc_q  <= '0;
			end
			tlsc_pkg::ST_GEN_ROW: begin
				new_q  <= new_row;
				prev_q <= cur_q;
				cur_q  <= next_row;
				x_q    <= '0;
				term_q <= base_q;
			end
			tlsc_pkg::ST_GEN_HASH: begin
				// serial hash walk over the new row
				acc_q  <= acc_nxt;
				term_q <= term_q + tlsc_pkg::X_WEIGHT;
				x_q    <= x_q + AW'(1);
				if (last_x) begin
					if (last_row) begin
						res_hash_q <= acc_nxt;
					end else begin
						y_q    <= y_q + AW'(1);
						base_q <= base_q + tlsc_pkg::Y_WEIGHT;
					end
				end
			end
			tlsc_pkg::ST_GEN_HIST: begin
				if (hist_rsp.done) begin
					res_rep_q <= hist_rsp.hit;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			cell_out_q    <= res_cell_q;
			grid_hash_q   <= res_hash_q;
			repeat_seen_q <= res_rep_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign cell_out    = cell_out_q;
	assign grid_hash   = grid_hash_q;
	assign repeat_seen = repeat_seen_q;

	// checks
	a_hist_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		hist_req.start |-> !hist_rsp.busy)
		else $error("history scan started while busy");

	a_hist_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		hist_rsp.done |-> (state_q == tlsc_pkg::ST_GEN_HIST))
		else $error("history scan finished outside its wait state");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == tlsc_pkg::ST_RESULT))
		else $error("result appeared without passing the result state");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tlsc_pkg::ST_GEN_ROW) |-> (DW'(y_q) < h_eff))
		else $error("generation row beyond active height");

endmodule
